>>> rtl/sha_pkg.sv
// Shared types, constants and helper functions for the SHA-256 engine.
`default_nettype none
package sha_pkg;

  // Input word: one message byte with its flags
  typedef struct packed {
    logic [7:0] byte_value;
    logic       byte_present;
    logic       is_last;
  } sha_in_t;

  // Output word: one digest word
  typedef struct packed {
    logic [31:0] digest_word;
    logic        word_is_last;
  } sha_out_t;

  // One 512-bit block handed from the front to the compression core
  typedef struct packed {
    logic [15:0][31:0] words;
    logic              fin;
  } sha_job_t;

  localparam int JobW = $bits(sha_job_t);

  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [5:0] LenPos  = 6'd56;
  localparam logic [5:0] LastPos = 6'd63;

  localparam logic [31:0] ShaIv [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ShaK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] ror32(input logic [31:0] v, input int n);
    ror32 = (v >> n) | (v << (32 - n));
  endfunction

  // Build a padded block: keep data below pos, 0x80 at pos, zeros after,
  // and the bit length in the tail when it fits. Without data, only length.
  function automatic logic [15:0][31:0] pad_block(input logic [15:0][31:0] words,
                                                  input logic [5:0] pos,
                                                  input logic [63:0] bits,
                                                  input logic with_data);
    logic [15:0][31:0] res;
    logic [7:0]        b;
    res = '0;
    for (int j = 0; j < 64; j++) begin
      b = 8'h00;
      if (with_data) begin
        if (6'(j) < pos) b = words[j / 4][8 * (3 - j % 4) +: 8];
        else if (6'(j) == pos) b = PadByte;
      end
      if (j >= 56 && (!with_data || pos < LenPos)) b = bits[8 * (63 - j) +: 8];
      res[j / 4][8 * (3 - j % 4) +: 8] = b;
    end
    pad_block = res;
  endfunction

endpackage
`default_nettype wire

>>> rtl/sha256_hash_engine_top.sv
// SHA-256 engine top level: byte front, job queue and compression core.
//
// Input channel (in_valid / in_stall / in_word): one word per message byte,
// with byte_present and is_last flags. A word with is_last closes the
// message; a word with neither flag set is dropped.
// Output channel (out_valid / out_stall / out_word): eight digest words per
// message, hash word 0 first, word_is_last set on the eighth.
// Throughput: one byte per cycle while the block buffer fills and the queue
// has room; each full block is queued and compressed by the core (load, 64
// rounds at one per cycle, fold), so long messages settle near one byte per
// cycle, limited by the single round unit. The two-entry queue lets filling
// continue while the core works. Closing a message queues one or two padding
// blocks; the digest appears once its last block has been loaded, run and
// folded, after every block still queued or running ahead of it.
// Reset (rst_n low, synchronous) restores the initial hash values and an
// empty buffer. A stalled receiver holds the digest; the core keeps
// compressing until it needs the digest buffer again, and the front stalls
// the sender when the queue is full.
`default_nettype none
module sha256_hash_engine_top import sha_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire sha_in_t  in_word,
  output logic          out_valid,
  input  wire logic     out_stall,
  output sha_out_t      out_word
);

  logic     q_push, q_full, q_pop, q_empty;
  sha_job_t push_job, pop_job;

  sha_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_job    (push_job)
  );

  sha_fifo #(.W(JobW)) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_job),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (pop_job),
    .empty     (q_empty)
  );

  sha_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_job     (pop_job),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule
`default_nettype wire

>>> rtl/sha_fifo.sv
// Two-entry job queue between the block front and the compression core.
`default_nettype none
module sha_fifo #(
  parameter int W = 8
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire logic [W-1:0] push_data,
  output logic              full,
  input  wire logic         pop,
  output logic [W-1:0]      pop_data,
  output logic              empty
);

  logic [W-1:0] mem_r [2];
  logic         wr_ptr_r, wr_ptr_nxt;
  logic         rd_ptr_r, rd_ptr_nxt;
  logic [1:0]   cnt_r, cnt_nxt;

  assign full     = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign pop_data = mem_r[rd_ptr_r];

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store pushed entry
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

endmodule
`default_nettype wire

>>> rtl/sha_front.sv
// Byte packer and padder: fills 512-bit blocks and queues them for compression.
`default_nettype none
module sha_front import sha_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire sha_in_t  in_word,
  input  wire logic     q_full,
  output logic          q_push,
  output sha_job_t      q_job
);

  typedef enum logic [2:0] {
    FILL = 3'b001,
    PAD  = 3'b010,
    PAD2 = 3'b100
  } fr_state_t;

  fr_state_t         state_r, state_nxt;
  logic [60:0]       count_r, count_nxt;
  logic [15:0][31:0] buf_r, buf_nxt;
  logic              accept;
  logic [5:0]        pos;
  logic [63:0]       bits;

  assign in_stall = (state_r != FILL) || q_full;
  assign accept   = in_valid && !in_stall;
  assign pos      = count_r[5:0];
  assign bits     = {count_r, 3'b000};

  // Take bytes, queue full blocks, then pad on the closing word
  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    buf_nxt   = buf_r;
    q_push    = 1'b0;
    q_job     = '{words: buf_r, fin: 1'b0};
    case (state_r)
      FILL: begin
        if (accept) begin
          if (in_word.byte_present) begin
            buf_nxt[pos[5:2]][8 * (3 - int'(pos[1:0])) +: 8] = in_word.byte_value;
            count_nxt = count_r + 61'd1;
            if (pos == LastPos) begin
              q_push = 1'b1;
              q_job  = '{words: buf_nxt, fin: 1'b0};
            end
          end
          if (in_word.is_last) state_nxt = PAD;
        end
      end
      PAD: begin
        if (!q_full) begin
          q_push = 1'b1;
          q_job  = '{words: pad_block(buf_r, pos, bits, 1'b1), fin: (pos < LenPos)};
          if (pos < LenPos) begin
            count_nxt = '0;
            state_nxt = FILL;
          end else begin
            state_nxt = PAD2;
          end
        end
      end
      PAD2: begin
        if (!q_full) begin
          q_push    = 1'b1;
          q_job     = '{words: pad_block(buf_r, pos, bits, 1'b0), fin: 1'b1};
          count_nxt = '0;
          state_nxt = FILL;
        end
      end
      default: state_nxt = FILL;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FILL;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    buf_r <= buf_nxt;
  end

endmodule
`default_nettype wire

>>> rtl/sha_core.sv
// Compression core: one round per cycle, chaining hash and digest output buffer.
`default_nettype none
module sha_core import sha_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     q_empty,
  input  wire sha_job_t q_job,
  output logic          q_pop,
  output logic          out_valid,
  input  wire logic     out_stall,
  output sha_out_t      out_word
);

  typedef enum logic [2:0] {
    IDLE = 3'b001,
    RUN  = 3'b010,
    ADD  = 3'b100
  } co_state_t;

  co_state_t         state_r, state_nxt;
  logic [5:0]        t_r, t_nxt;
  logic              fin_r, fin_nxt;
  logic [31:0]       hash_r [8];
  logic [31:0]       hash_nxt [8];
  logic [31:0]       wk_r [8];
  logic [31:0]       wk_nxt [8];
  logic [15:0][31:0] w_r, w_nxt;
  logic [31:0]       dig_r [8];
  logic [31:0]       dig_nxt [8];
  logic [2:0]        ocnt_r, ocnt_nxt;
  logic              obusy_r, obusy_nxt;
  logic [31:0]       s0, s1, ch, mj, t1, t2, sg0, sg1, w_new;
  logic              out_take;

  assign out_valid = obusy_r;
  assign out_word  = '{digest_word: dig_r[0], word_is_last: (ocnt_r == 3'd7)};
  assign out_take  = obusy_r && !out_stall;
  assign q_pop     = (state_r == IDLE) && !q_empty;

  // Round and schedule datapath
  always_comb begin
    s1    = ror32(wk_r[4], 6) ^ ror32(wk_r[4], 11) ^ ror32(wk_r[4], 25);
    ch    = (wk_r[4] & wk_r[5]) ^ (~wk_r[4] & wk_r[6]);
    t1    = wk_r[7] + s1 + ch + ShaK[t_r] + w_r[0];
    s0    = ror32(wk_r[0], 2) ^ ror32(wk_r[0], 13) ^ ror32(wk_r[0], 22);
    mj    = (wk_r[0] & wk_r[1]) ^ (wk_r[0] & wk_r[2]) ^ (wk_r[1] & wk_r[2]);
    t2    = s0 + mj;
    sg0   = ror32(w_r[1], 7) ^ ror32(w_r[1], 18) ^ (w_r[1] >> 3);
    sg1   = ror32(w_r[14], 17) ^ ror32(w_r[14], 19) ^ (w_r[14] >> 10);
    w_new = w_r[0] + sg0 + w_r[9] + sg1;
  end

  // Sequence: load block, 64 rounds, fold into hash, hand digest off
  always_comb begin
    state_nxt = state_r;
    t_nxt     = t_r;
    fin_nxt   = fin_r;
    hash_nxt  = hash_r;
    wk_nxt    = wk_r;
    w_nxt     = w_r;
    dig_nxt   = dig_r;
    ocnt_nxt  = ocnt_r;
    obusy_nxt = obusy_r;

    // Drain digest words, first word first
    if (out_take) begin
      for (int i = 0; i < 7; i++) dig_nxt[i] = dig_r[i + 1];
      ocnt_nxt = ocnt_r + 3'd1;
      if (ocnt_r == 3'd7) obusy_nxt = 1'b0;
    end

    case (state_r)
      IDLE: begin
        if (!q_empty) begin
          w_nxt     = q_job.words;
          fin_nxt   = q_job.fin;
          wk_nxt    = hash_r;
          t_nxt     = '0;
          state_nxt = RUN;
        end
      end
      RUN: begin
        wk_nxt[7] = wk_r[6];
        wk_nxt[6] = wk_r[5];
        wk_nxt[5] = wk_r[4];
        wk_nxt[4] = wk_r[3] + t1;
        wk_nxt[3] = wk_r[2];
        wk_nxt[2] = wk_r[1];
        wk_nxt[1] = wk_r[0];
        wk_nxt[0] = t1 + t2;
        w_nxt     = {w_new, w_r[15:1]};
        t_nxt     = t_r + 6'd1;
        if (t_r == 6'd63) state_nxt = ADD;
      end
      ADD: begin
        if (!fin_r) begin
          for (int i = 0; i < 8; i++) hash_nxt[i] = hash_r[i] + wk_r[i];
          state_nxt = IDLE;
        end else if (!obusy_r) begin
          for (int i = 0; i < 8; i++) dig_nxt[i] = hash_r[i] + wk_r[i];
          hash_nxt  = ShaIv;
          ocnt_nxt  = '0;
          obusy_nxt = 1'b1;
          state_nxt = IDLE;
        end
      end
      default: state_nxt = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= IDLE;
      obusy_r <= 1'b0;
      ocnt_r  <= '0;
      hash_r  <= ShaIv;
    end else begin
      state_r <= state_nxt;
      obusy_r <= obusy_nxt;
      ocnt_r  <= ocnt_nxt;
      hash_r  <= hash_nxt;
    end
  end

  always_ff @(posedge clk) begin
    t_r   <= t_nxt;
    fin_r <= fin_nxt;
    wk_r  <= wk_nxt;
    w_r   <= w_nxt;
    dig_r <= dig_nxt;
  end

endmodule
`default_nettype wire
